[rtl/csdm_pkg.sv]
package csdm_pkg;

  localparam int DUTY_MAX = 1023;
  localparam int DUTY_LIM = (DUTY_MAX < 1023) ? DUTY_MAX : 1023;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // register index = paddr[4:2]
  localparam logic [2:0] REG_SPEED_DB  = 3'd0;
  localparam logic [2:0] REG_ANGLE_DB  = 3'd1;
  localparam logic [2:0] REG_PIVOT     = 3'd2;
  localparam logic [2:0] REG_MIN_ANGLE = 3'd3;
  localparam logic [2:0] REG_MAX_ANGLE = 3'd4;

  localparam logic [9:0] SPEED_DB_RST  = 10'd50;
  localparam logic [7:0] ANGLE_DB_RST  = 8'd5;
  localparam logic [9:0] PIVOT_RST     = 10'd255;
  localparam logic [8:0] MIN_ANGLE_RST = 9'd90;
  localparam logic [8:0] MAX_ANGLE_RST = 9'd270;

  localparam logic [6:0] POS_UNKNOWN = 7'd64;

  // angle = floor(pos * 2.8345) as (pos * round(2.8345 * 2^18)) >> 18, exact for pos < 128
  localparam logic [19:0] ANGLE_MUL   = 20'd743047;
  localparam int          ANGLE_SHIFT = 18;
  // m / 10 as (m * 6554) >> 16, exact for m <= 1024
  localparam logic [12:0] TENTH_MUL   = 13'd6554;
  localparam int          TENTH_SHIFT = 16;

  localparam logic [7:0] CODE_OF_POS [128] = '{
    8'd127, 8'd63,  8'd62,  8'd58,  8'd56,  8'd184, 8'd152, 8'd24,
    8'd8,   8'd72,  8'd73,  8'd77,  8'd79,  8'd15,  8'd47,  8'd175,
    8'd191, 8'd159, 8'd31,  8'd29,  8'd28,  8'd92,  8'd76,  8'd12,
    8'd4,   8'd36,  8'd164, 8'd166, 8'd167, 8'd135, 8'd151, 8'd215,
    8'd223, 8'd207, 8'd143, 8'd142, 8'd14,  8'd46,  8'd38,  8'd6,
    8'd2,   8'd18,  8'd82,  8'd83,  8'd211, 8'd195, 8'd203, 8'd235,
    8'd239, 8'd231, 8'd199, 8'd71,  8'd7,   8'd23,  8'd19,  8'd3,
    8'd1,   8'd9,   8'd41,  8'd169, 8'd233, 8'd225, 8'd229, 8'd245,
    8'd247, 8'd243, 8'd227, 8'd163, 8'd131, 8'd139, 8'd137, 8'd129,
    8'd128, 8'd132, 8'd148, 8'd212, 8'd244, 8'd240, 8'd242, 8'd250,
    8'd251, 8'd249, 8'd241, 8'd209, 8'd193, 8'd197, 8'd196, 8'd192,
    8'd64,  8'd66,  8'd74,  8'd106, 8'd122, 8'd120, 8'd121, 8'd125,
    8'd253, 8'd252, 8'd248, 8'd232, 8'd224, 8'd226, 8'd98,  8'd96,
    8'd32,  8'd33,  8'd37,  8'd53,  8'd61,  8'd60,  8'd188, 8'd190,
    8'd254, 8'd126, 8'd124, 8'd116, 8'd112, 8'd113, 8'd49,  8'd48,
    8'd16,  8'd144, 8'd146, 8'd154, 8'd158, 8'd30,  8'd94,  8'd95
  };

  typedef struct packed {
    logic [7:0] encoder_code;
    logic [8:0] target_angle;
    logic [9:0] speed_command;
  } in_t;

  typedef struct packed {
    logic [9:0] left_duty;
    logic [9:0] right_duty;
    logic       left_reverse;
    logic       right_reverse;
    logic [8:0] caster_angle;
  } out_t;

  typedef struct packed {
    logic [9:0] speed_deadband;
    logic [7:0] angle_deadband;
    logic [9:0] pivot_duty;
    logic [8:0] min_target_angle;
    logic [8:0] max_target_angle;
  } cfg_t;

  // codes are unique in the table, so OR-ing the matching index is a plain lookup
  function automatic logic [6:0] decode_position(input logic [7:0] code);
    logic [6:0] pos;
    logic       hit;
    pos = '0;
    hit = 1'b0;
    for (int i = 0; i < 128; i++) begin
      if (CODE_OF_POS[i] == code) begin
        pos = pos | 7'(i);
        hit = 1'b1;
      end
    end
    return hit ? pos : POS_UNKNOWN;
  endfunction

endpackage

[rtl/csdm_cfg_regs.sv]
module csdm_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [csdm_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [csdm_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [csdm_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready,
  output csdm_pkg::cfg_t                   cfg
);

  csdm_pkg::cfg_t cfg_r;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx        = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_deadband   <= csdm_pkg::SPEED_DB_RST;
      cfg_r.angle_deadband   <= csdm_pkg::ANGLE_DB_RST;
      cfg_r.pivot_duty       <= csdm_pkg::PIVOT_RST;
      cfg_r.min_target_angle <= csdm_pkg::MIN_ANGLE_RST;
      cfg_r.max_target_angle <= csdm_pkg::MAX_ANGLE_RST;
    end else if (wr_en) begin
      case (idx)
        csdm_pkg::REG_SPEED_DB:  cfg_r.speed_deadband   <= cfg_pwdata[9:0];
        csdm_pkg::REG_ANGLE_DB:  cfg_r.angle_deadband   <= cfg_pwdata[7:0];
        csdm_pkg::REG_PIVOT:     cfg_r.pivot_duty       <= cfg_pwdata[9:0];
        csdm_pkg::REG_MIN_ANGLE: cfg_r.min_target_angle <= cfg_pwdata[8:0];
        csdm_pkg::REG_MAX_ANGLE: cfg_r.max_target_angle <= cfg_pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    case (idx)
      csdm_pkg::REG_SPEED_DB:  cfg_prdata = 32'(cfg_r.speed_deadband);
      csdm_pkg::REG_ANGLE_DB:  cfg_prdata = 32'(cfg_r.angle_deadband);
      csdm_pkg::REG_PIVOT:     cfg_prdata = 32'(cfg_r.pivot_duty);
      csdm_pkg::REG_MIN_ANGLE: cfg_prdata = 32'(cfg_r.min_target_angle);
      csdm_pkg::REG_MAX_ANGLE: cfg_prdata = 32'(cfg_r.max_target_angle);
      default:                 cfg_prdata = '0;
    endcase
  end

endmodule

[rtl/csdm_mix.sv]
module csdm_mix (
  input  csdm_pkg::in_t  item,
  input  csdm_pkg::cfg_t cfg,
  output csdm_pkg::out_t res
);

  logic [6:0]         pos;
  logic [26:0]        angle_prod;
  logic [8:0]         angle;
  logic [8:0]         tgt;
  logic signed [10:0] err;
  logic signed [10:0] db_s;
  logic               right;
  logic               left;
  logic signed [11:0] mag;
  logic [11:0]        mag_neg;
  logic [10:0]        m;
  logic [23:0]        tenth_prod;
  logic [10:0]        tenth;
  logic               drive;
  logic [10:0]        a_val;
  logic [10:0]        b_val;
  logic [10:0]        l_val;
  logic [10:0]        r_val;
  logic               l_dir;
  logic               r_dir;

  function automatic logic [9:0] sat_duty(input logic [10:0] v);
    return (v > 11'(csdm_pkg::DUTY_LIM)) ? 10'(csdm_pkg::DUTY_LIM) : v[9:0];
  endfunction

  always_comb begin
    pos        = csdm_pkg::decode_position(item.encoder_code);
    angle_prod = 27'(pos) * 27'(csdm_pkg::ANGLE_MUL);
    angle      = angle_prod[csdm_pkg::ANGLE_SHIFT +: 9];

    // max bound is checked first: when the bounds cross, a target above max gets max, any other gets min
    if (item.target_angle > cfg.max_target_angle)
      tgt = cfg.max_target_angle;
    else if (item.target_angle < cfg.min_target_angle)
      tgt = cfg.min_target_angle;
    else
      tgt = item.target_angle;

    err   = $signed({2'b00, angle}) - $signed({2'b00, tgt});
    db_s  = $signed({3'b000, cfg.angle_deadband});
    right = err > db_s;
    left  = err < -db_s;

    mag     = $signed({1'b0, item.speed_command, 1'b0}) - 12'sd1024;
    mag_neg = 12'(-mag);
    m       = mag[11] ? mag_neg[10:0] : mag[10:0];
    drive   = m > {1'b0, cfg.speed_deadband};

    tenth_prod = 24'(m) * 24'(csdm_pkg::TENTH_MUL);
    tenth      = {4'b0000, tenth_prod[csdm_pkg::TENTH_SHIFT +: 7]};

    a_val = right ? tenth : m;
    b_val = (!right && left) ? tenth : m;

    l_val = '0;
    r_val = '0;
    l_dir = 1'b0;
    r_dir = 1'b0;
    if (drive) begin
      if (!mag[11]) begin
        l_val = a_val;
        r_val = b_val;
      end else begin
        // reverse: inner wheel swaps sides
        l_val = b_val;
        r_val = a_val;
        l_dir = 1'b1;
        r_dir = 1'b1;
      end
    end else if (right) begin
      l_val = {1'b0, cfg.pivot_duty};
      r_val = {1'b0, cfg.pivot_duty};
      r_dir = 1'b1;
    end else if (left) begin
      l_val = {1'b0, cfg.pivot_duty};
      r_val = {1'b0, cfg.pivot_duty};
      l_dir = 1'b1;
    end

    res.left_duty     = sat_duty(l_val);
    res.right_duty    = sat_duty(r_val);
    res.left_reverse  = l_dir;
    res.right_reverse = r_dir;
    res.caster_angle  = angle;
  end

endmodule

[rtl/caster_steering_drive_mixer.sv]
// Caster steering drive mixer.
// Input channel in_valid/in_stall/in_data carries the encoder code, the
// commanded heading and the commanded speed; each item gives exactly one
// result on out_valid/out_stall/out_data: both wheel duties and directions
// and the decoded caster angle.
// An accepted item lands in the input register, is decoded and mixed in one
// combinational pass and is captured in the output register once that register
// is free. One item is taken per cycle while in_stall is low.
// in_stall rises only when both the input and the output register hold an
// item and the receiver stalls; otherwise a new item is taken while the
// current result waits. A stalled result holds steady.
// Five registers sit on the cfg_ APB port at byte addresses 0, 4, ..., 16:
// speed deadband, angle deadband, pivot duty, minimum and maximum heading.
// Write them only when the block is idle. Reset (rst_n low, synchronous)
// empties both registers and loads the register defaults 50, 5, 255, 90, 270.
module caster_steering_drive_mixer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  csdm_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output csdm_pkg::out_t                   out_data,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [csdm_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [csdm_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [csdm_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);

  csdm_pkg::cfg_t cfg;
  csdm_pkg::in_t  s1_data_r;
  logic           s1_valid_r;
  csdm_pkg::out_t mix_res;
  csdm_pkg::out_t out_data_r;
  logic           out_valid_r;
  logic           out_free;
  logic           s1_free;
  logic           in_fire;

  csdm_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  csdm_mix u_mix (
    .item (s1_data_r),
    .cfg  (cfg),
    .res  (mix_res)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_free   = !s1_valid_r || out_free;
  assign in_stall  = !s1_free;
  assign in_fire   = in_valid && s1_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free)
        s1_valid_r <= in_valid;
      if (out_free)
        out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire)
      s1_data_r <= in_data;
    if (out_free && s1_valid_r)
      out_data_r <= mix_res;
  end

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> s1_valid_r)
    else $error("accepted item not held in input register");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled while pipeline has room");

  a_out_takes_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && (!out_valid_r || !out_stall)) |=> out_valid_r)
    else $error("item dropped between input and output register");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.caster_angle <= 9'd359))
    else $error("caster angle out of range");

  a_pivot_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.left_reverse != out_data_r.right_reverse))
      |-> (out_data_r.left_duty == out_data_r.right_duty))
    else $error("pivot duties differ");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int IDLE_LIMIT = 4000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  csdm_pkg::in_t  in_data;
  logic out_valid;
  logic out_stall;
  csdm_pkg::out_t out_data;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [csdm_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [csdm_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [csdm_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  caster_steering_drive_mixer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  typedef struct {
    csdm_pkg::in_t  item;
    bit             typed;
    csdm_pkg::out_t want;
  } drive_row_t;

  csdm_pkg::cfg_t mix_cfg;
  csdm_pkg::out_t motor_q[$];
  drive_row_t     drive_rows[$];
  bit             row_typed;
  csdm_pkg::out_t row_want;
  int             src_pct;
  int             snk_pct;
  int             n_items;
  int             n_results;
  int             n_settings;
  int             n_errors;
  int             quiet_cycles;
  csdm_pkg::out_t head;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // drive commands for one item: lookup, clamp, deadbands, tenth inner wheel
  function automatic csdm_pkg::out_t mix_predict(csdm_pkg::in_t d, csdm_pkg::cfg_t c);
    int   pos, angle, tgt, err, mag, m, tenth, a, b, lv, rv, adb, sdb;
    bit   turn_r, turn_l, lrev, rrev;
    csdm_pkg::out_t r;
    pos = 64;
    for (int i = 0; i < 128; i++)
      if (csdm_pkg::CODE_OF_POS[i] == d.encoder_code) pos = i;
    angle = pos * 28345 / 10000;
    tgt = int'(d.target_angle);
    if (tgt > int'(c.max_target_angle)) tgt = int'(c.max_target_angle);
    else if (tgt < int'(c.min_target_angle)) tgt = int'(c.min_target_angle);
    adb = int'(c.angle_deadband);
    sdb = int'(c.speed_deadband);
    err = angle - tgt;
    turn_r = err > adb;
    turn_l = err < -adb;
    mag = 2 * (int'(d.speed_command) - 512);
    lv = 0;
    rv = 0;
    lrev = 1'b0;
    rrev = 1'b0;
    if (mag > sdb || mag < -sdb) begin
      m = (mag < 0) ? -mag : mag;
      tenth = m / 10;
      a = m;
      b = m;
      if (turn_r) a = tenth;
      else if (turn_l) b = tenth;
      if (mag > 0) begin
        lv = a;
        rv = b;
      end else begin
        lv = b;
        rv = a;
        lrev = 1'b1;
        rrev = 1'b1;
      end
    end else if (turn_r) begin
      lv = int'(c.pivot_duty);
      rv = int'(c.pivot_duty);
      rrev = 1'b1;
    end else if (turn_l) begin
      lv = int'(c.pivot_duty);
      rv = int'(c.pivot_duty);
      lrev = 1'b1;
    end
    r.left_duty = (lv > csdm_pkg::DUTY_LIM) ? 10'(csdm_pkg::DUTY_LIM) : 10'(lv);
    r.right_duty = (rv > csdm_pkg::DUTY_LIM) ? 10'(csdm_pkg::DUTY_LIM) : 10'(rv);
    r.left_reverse = lrev;
    r.right_reverse = rrev;
    r.caster_angle = 9'(angle);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d want %0d (result %0d)", $time, what, got, want,
             n_results);
    n_errors++;
  endtask

  // scoreboard: queue a prediction (or the typed result) per accepted item, check accepted results in order
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        motor_q.push_back(row_typed ? row_want : mix_predict(in_data, mix_cfg));
        n_items++;
      end
      if (out_valid && !out_stall) begin
        if (motor_q.size() == 0) begin
          report_mismatch("result with nothing pending", 0, 0);
        end else begin
          head = motor_q.pop_front();
          if (out_data.left_duty !== head.left_duty)
            report_mismatch("left_duty", out_data.left_duty, head.left_duty);
          if (out_data.right_duty !== head.right_duty)
            report_mismatch("right_duty", out_data.right_duty, head.right_duty);
          if (out_data.left_reverse !== head.left_reverse)
            report_mismatch("left_reverse", out_data.left_reverse, head.left_reverse);
          if (out_data.right_reverse !== head.right_reverse)
            report_mismatch("right_reverse", out_data.right_reverse, head.right_reverse);
          if (out_data.caster_angle !== head.caster_angle)
            report_mismatch("caster_angle", out_data.caster_angle, head.caster_angle);
        end
        n_results++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d results pending",
               quiet_cycles, motor_q.size());
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(negedge clk)
    out_stall <= rst_n && ($urandom_range(0, 99) < snk_pct);

  task automatic send_item(csdm_pkg::in_t d, bit typed, csdm_pkg::out_t want);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      csdm_pkg::REG_SPEED_DB:  mix_cfg.speed_deadband = val[9:0];
      csdm_pkg::REG_ANGLE_DB:  mix_cfg.angle_deadband = val[7:0];
      csdm_pkg::REG_PIVOT:     mix_cfg.pivot_duty = val[9:0];
      csdm_pkg::REG_MIN_ANGLE: mix_cfg.min_target_angle = val[8:0];
      csdm_pkg::REG_MAX_ANGLE: mix_cfg.max_target_angle = val[8:0];
      default: ;
    endcase
  endtask

  // pause the sender until every result is back, then reprogram
  task automatic set_mix_cfg(logic [31:0] sdb, logic [31:0] adb, logic [31:0] piv,
                             logic [31:0] amin, logic [31:0] amax);
    @(negedge clk);
    in_valid <= 1'b0;
    wait (motor_q.size() == 0);
    repeat (3) @(negedge clk);
    reg_write(csdm_pkg::REG_SPEED_DB, sdb);
    reg_write(csdm_pkg::REG_ANGLE_DB, adb);
    reg_write(csdm_pkg::REG_PIVOT, piv);
    reg_write(csdm_pkg::REG_MIN_ANGLE, amin);
    reg_write(csdm_pkg::REG_MAX_ANGLE, amax);
    n_settings++;
  endtask

  function automatic void add_row(int code, int tgt, int spd, bit typed,
                                  int ld = 0, int rd = 0, int lr = 0, int rr = 0,
                                  int ang = 0);
    drive_row_t row;
    row.item.encoder_code = 8'(code);
    row.item.target_angle = 9'(tgt);
    row.item.speed_command = 10'(spd);
    row.typed = typed;
    row.want.left_duty = 10'(ld);
    row.want.right_duty = 10'(rd);
    row.want.left_reverse = lr[0];
    row.want.right_reverse = rr[0];
    row.want.caster_angle = 9'(ang);
    drive_rows.push_back(row);
  endfunction

  // random items, biased toward the deadband and clamp edges
  task automatic run_phase(int src, int snk, int count);
    csdm_pkg::in_t  d;
    csdm_pkg::out_t none;
    int   p, angle, tgt, spd, half;
    src_pct = src;
    snk_pct = snk;
    none = '0;
    for (int k = 0; k < count; k++) begin
      p = $urandom_range(0, 127);
      angle = p * 28345 / 10000;
      d.encoder_code = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                     : csdm_pkg::CODE_OF_POS[p];
      case ($urandom_range(0, 3))
        0: tgt = $urandom_range(0, 511);
        1: tgt = $urandom_range(0, 360);
        2: tgt = (($urandom_range(0, 1) == 0) ? int'(mix_cfg.min_target_angle)
                                               : int'(mix_cfg.max_target_angle))
                 + $urandom_range(0, 6) - 3;
        default: tgt = angle + (($urandom_range(0, 1) == 0) ? 1 : -1)
                       * (int'(mix_cfg.angle_deadband) + $urandom_range(0, 1));
      endcase
      half = int'(mix_cfg.speed_deadband) / 2;
      case ($urandom_range(0, 3))
        0: spd = $urandom_range(0, 1023);
        1: spd = 512 + (($urandom_range(0, 1) == 0) ? 1 : -1) * (half + $urandom_range(0, 2));
        2: spd = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 8) : $urandom_range(1015, 1023);
        default: spd = 512 + $urandom_range(0, 2 * half) - half;
      endcase
      if (tgt < 0) tgt = 0;
      if (tgt > 511) tgt = 511;
      if (spd < 0) spd = 0;
      if (spd > 1023) spd = 1023;
      d.target_angle = 9'(tgt);
      d.speed_command = 10'(spd);
      send_item(d, 1'b0, none);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    row_typed = 1'b0;
    row_want = '0;
    src_pct = 0;
    snk_pct = 0;
    n_items = 0;
    n_results = 0;
    n_settings = 1;
    n_errors = 0;
    quiet_cycles = 0;
    mix_cfg.speed_deadband = csdm_pkg::SPEED_DB_RST;
    mix_cfg.angle_deadband = csdm_pkg::ANGLE_DB_RST;
    mix_cfg.pivot_duty = csdm_pkg::PIVOT_RST;
    mix_cfg.min_target_angle = csdm_pkg::MIN_ANGLE_RST;
    mix_cfg.max_target_angle = csdm_pkg::MAX_ANGLE_RST;

    // reset defaults; unknown codes 0 and 255 decode to 181 degrees
    add_row(127, 0, 1023, 1, 1022, 102, 0, 0, 0);    // full forward, turning left
    add_row(95, 511, 0, 1, 1023, 102, 1, 1, 359);    // full reverse, saturates
    add_row(0, 181, 512, 1, 0, 0, 0, 0, 181);        // stopped
    add_row(255, 180, 512, 1, 0, 0, 0, 0, 181);
    add_row(0, 90, 530, 1, 255, 255, 0, 1, 181);     // pivot right
    add_row(0, 270, 500, 1, 255, 255, 1, 0, 181);    // pivot left
    add_row(0, 181, 600, 1, 176, 176, 0, 0, 181);
    add_row(0, 181, 400, 1, 224, 224, 1, 1, 181);
    add_row(0, 181, 537, 1, 0, 0, 0, 0, 181);        // speed band edges
    add_row(0, 181, 538, 1, 52, 52, 0, 0, 181);
    add_row(0, 181, 487, 1, 0, 0, 0, 0, 181);
    add_row(0, 181, 486, 1, 52, 52, 1, 1, 181);
    add_row(0, 176, 512, 1, 0, 0, 0, 0, 181);        // angle band edges
    add_row(0, 175, 512, 1, 255, 255, 0, 1, 181);
    add_row(0, 186, 512, 1, 0, 0, 0, 0, 181);
    add_row(0, 187, 512, 1, 255, 255, 1, 0, 181);
    add_row(0, 100, 1023, 1, 102, 1022, 0, 0, 181);
    add_row(0, 100, 0, 1, 1023, 102, 1, 1, 181);
    add_row(127, 300, 0, 1, 102, 1023, 1, 1, 0);
    add_row(128, 360, 700, 0);
    add_row(1, 0, 511, 0);
    add_row(254, 256, 1, 0);
    add_row(170, 85, 682, 0);

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (drive_rows[i])
      send_item(drive_rows[i].item, drive_rows[i].typed, drive_rows[i].want);
    @(negedge clk);
    in_valid <= 1'b0;
    wait (motor_q.size() == 0);

    run_phase(0, 0, 200);
    set_mix_cfg(0, 0, 0, 0, 0);
    run_phase(46, 0, 200);
    set_mix_cfg(1023, 255, 1023, 511, 511);
    run_phase(0, 46, 200);
    // crossed clamp bounds: min above max
    set_mix_cfg(20, 10, 700, 300, 100);
    run_phase(12, 12, 200);
    set_mix_cfg(0, 180, 1023, 0, 360);
    run_phase(0, 0, 200);
    set_mix_cfg($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    run_phase(46, 0, 200);
    set_mix_cfg($urandom_range(0, 200), $urandom_range(0, 30), $urandom(),
                $urandom_range(0, 180), $urandom_range(180, 360));
    run_phase(0, 46, 200);

    @(negedge clk);
    in_valid <= 1'b0;
    wait (motor_q.size() == 0);
    repeat (10) @(posedge clk);

    $display("ran %0d items and checked %0d results across %0d register settings,",
             n_items, n_results, n_settings);
    $display("with free-running, sender-idle, receiver-stall and mixed traffic");
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/csdm_pkg.sv
rtl/csdm_cfg_regs.sv
rtl/csdm_mix.sv
rtl/caster_steering_drive_mixer.sv
sim/tb_top.sv
